### design/nnc_pkg.sv
// ----------------------------------------------------------------------------
// nnc_pkg
// shared types and codes for the nearest-neighbour-chain engine
// ----------------------------------------------------------------------------
package nnc_pkg;

  // operation codes carried by an input item
  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_WRITE = 3'd1,
    OP_GROW  = 3'd2,
    OP_MERGE = 3'd3,
    OP_TRIM  = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  localparam logic [6:0] ELEM_COUNT_RST = 7'd64;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_WSLOT,
    S_WRITE,
    S_INIT_SET,
    S_INIT_FILL,
    S_GROW,
    S_SEED,
    S_STEP,
    S_SCAN,
    S_DECIDE,
    S_MERGE,
    S_COMPACT,
    S_APPEND,
    S_TRIM,
    S_TRD1,
    S_TRD2,
    S_TRD3,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    init_set;
    logic    init_fill;
    logic    slot_calc;
    logic    dist_write;
    logic    seed_read;
    logic    seed_push;
    logic    scan_begin;
    logic    scan_go;
    logic    push;
    logic    compact_begin;
    logic    compact_go;
    logic    compact_end;
    logic    append;
    logic    trim;
    logic    stk_rd_top;
    logic    stk_rd_below;
    logic    load_top;
    logic    load_below;
    logic    set_status;
    status_t status_code;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       depth_zero;
    logic       start_bad;
    logic       step_more;
    logic       scan_done;
    logic       have;
    logic       nb_is_below;
    logic       depth_full;
    logic       init_done;
    logic       compact_done;
    logic       pass_last;
    logic       list_full;
    logic       out_free;
  } stat_t;

endpackage

### design/nnc_ctrl.sv
// ----------------------------------------------------------------------------
// nnc_ctrl
// sequencing state machine: decodes an item and steps the datapath through it
// ----------------------------------------------------------------------------
module nnc_ctrl
  import nnc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_INIT:  state_nxt = S_INIT_SET;
          OP_WRITE: state_nxt = S_WSLOT;
          OP_GROW:  state_nxt = S_GROW;
          OP_MERGE: state_nxt = S_MERGE;
          OP_TRIM:  state_nxt = S_TRIM;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_WSLOT:     state_nxt = S_WRITE;
      S_WRITE:     state_nxt = S_DONE;
      S_INIT_SET:  state_nxt = S_INIT_FILL;
      S_INIT_FILL: begin
        if (stat.init_done) state_nxt = S_DONE;
      end
      S_GROW: begin
        if (!stat.depth_zero) state_nxt = S_STEP;
        else if (stat.start_bad) state_nxt = S_DONE;
        else state_nxt = S_SEED;
      end
      S_SEED:      state_nxt = S_STEP;
      S_STEP: begin
        state_nxt = stat.step_more ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.have || stat.nb_is_below || stat.depth_full) state_nxt = S_DONE;
        else state_nxt = S_STEP;
      end
      S_MERGE:     state_nxt = S_COMPACT;
      S_COMPACT: begin
        if (stat.compact_done && stat.pass_last) state_nxt = S_APPEND;
      end
      S_APPEND:    state_nxt = S_DONE;
      S_TRIM:      state_nxt = S_TRD1;
      S_TRD1:      state_nxt = S_TRD2;
      S_TRD2:      state_nxt = S_TRD3;
      S_TRD3:      state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status_code = ST_OK;
    unique case (state_r)
      S_IDLE:      cmd.latch = in_valid;
      S_WSLOT:     cmd.slot_calc = 1'b1;
      S_WRITE:     cmd.dist_write = 1'b1;
      S_INIT_SET:  cmd.init_set = 1'b1;
      S_INIT_FILL: cmd.init_fill = !stat.init_done;
      S_GROW: begin
        if (stat.depth_zero) begin
          if (stat.start_bad) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_BAD;
          end else begin
            cmd.seed_read = 1'b1;
          end
        end
      end
      S_SEED:      cmd.seed_push = 1'b1;
      S_STEP:      cmd.scan_begin = stat.step_more;
      S_SCAN:      cmd.scan_go = 1'b1;
      S_DECIDE: begin
        if (!stat.have) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NONE;
        end else if (stat.nb_is_below) begin
          cmd.set_status  = 1'b0;
        end else if (stat.depth_full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_FULL;
        end else begin
          cmd.push = 1'b1;
        end
      end
      S_MERGE:     cmd.compact_begin = 1'b1;
      S_COMPACT: begin
        cmd.compact_go  = !stat.compact_done;
        cmd.compact_end = stat.compact_done;
      end
      S_APPEND: begin
        if (stat.list_full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_FULL;
        end else begin
          cmd.append = 1'b1;
        end
      end
      S_TRIM:      cmd.trim = 1'b1;
      S_TRD1:      cmd.stk_rd_top = 1'b1;
      S_TRD2: begin
        cmd.load_top     = 1'b1;
        cmd.stk_rd_below = 1'b1;
      end
      S_TRD3:      cmd.load_below = 1'b1;
      S_DONE:      cmd.out_load = stat.out_free;
      default:     cmd.latch = 1'b0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTH
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");
`endif

endmodule

### design/nnc_dpath.sv
// ----------------------------------------------------------------------------
// nnc_dpath
// distance store, active list, chain stack, counters and nearest scan
// ----------------------------------------------------------------------------
module nnc_dpath
  import nnc_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64,
  parameter int DIST_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_first_index,
  input  logic [6:0]  in_second_index,
  input  logic [31:0] in_distance_value,
  input  logic [5:0]  in_merge_step,
  input  logic [5:0]  in_start_position,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_pair_first,
  output logic [6:0]  out_pair_second,
  output logic [6:0]  out_chain_length,
  output logic [6:0]  out_active_count
);

  localparam int AW          = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW          = AW + 1;
  localparam int SPAN        = 2 * MAX_ELEMENTS - 1;
  localparam int HI_CNT      = (SPAN < 128) ? SPAN : 128;
  localparam int STORE_DEPTH = HI_CNT * (HI_CNT + 1) / 2;
  localparam int SW          = $clog2(STORE_DEPTH);
  localparam logic [9:0]    SPAN_L = 10'(SPAN);
  localparam logic [9:0]    MAX_L  = 10'(MAX_ELEMENTS);
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_ELEMENTS);

  // {out of range, triangular slot}
  function automatic logic [14:0] slot_of(input logic [6:0] a, input logic [6:0] b);
    logic [6:0]  hi;
    logic [6:0]  lo;
    logic [14:0] prod;
    logic [13:0] slot;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    prod = {8'd0, hi} * ({8'd0, hi} + 15'd1);
    slot = prod[14:1] + {7'd0, lo};
    return {({3'd0, hi} >= SPAN_L), slot};
  endfunction

  // memories
  logic [DIST_WIDTH-1:0] dist_mem [STORE_DEPTH];
  logic [6:0]            al_mem   [MAX_ELEMENTS];
  logic [6:0]            stk_mem  [MAX_ELEMENTS];

  // item fields
  logic [2:0]            op_r;
  logic [6:0]            fa_r;
  logic [6:0]            fb_r;
  logic [DIST_WIDTH-1:0] dv_r;
  logic [5:0]            ms_r;
  logic [5:0]            sp_r;

  // state
  logic [6:0]            ec_r;
  logic [CW-1:0]         total_r;
  logic [CW-1:0]         depth_r;
  logic [CW-1:0]         step_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         wcnt_r;
  logic                  pass_r;
  logic [6:0]            top_r;
  logic [6:0]            below_r;
  status_t               status_r;
  logic [SW-1:0]         slot_r;
  logic                  slot_oob_r;

  // scan pipeline
  logic                  v1_r;
  logic                  v2_r;
  logic                  v3_r;
  logic [SW-1:0]         slot_s2_r;
  logic                  oob_s2_r;
  logic                  skip_s2_r;
  logic [6:0]            j_s2_r;
  logic                  oob_s3_r;
  logic                  skip_s3_r;
  logic [6:0]            j_s3_r;
  logic                  have_r;
  logic [DIST_WIDTH-1:0] best_r;
  logic [6:0]            best_j_r;

  logic [6:0]            al_rdata_r;
  logic [6:0]            stk_rdata_r;
  logic [DIST_WIDTH-1:0] dist_rdata_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [6:0]            out_pair_first_r;
  logic [6:0]            out_pair_second_r;
  logic [6:0]            out_chain_length_r;
  logic [6:0]            out_active_count_r;

  logic [9:0]            ec_ext;
  logic [CW-1:0]         elem_lim;
  logic                  issue_rd;
  logic [6:0]            pass_val;
  logic                  keep_wr;
  logic [AW-1:0]         al_raddr;
  logic                  al_we;
  logic [AW-1:0]         al_waddr;
  logic [6:0]            al_wdata;
  logic                  stk_we;
  logic [AW-1:0]         stk_waddr;
  logic [6:0]            stk_wdata;
  logic [CW-1:0]         dm1;
  logic [CW-1:0]         dm2;
  logic [AW-1:0]         stk_raddr;
  logic [14:0]           wslot;
  logic [14:0]           sslot;
  logic [DIST_WIDTH-1:0] d_cur;
  logic                  better;

  assign ec_ext   = {3'd0, ec_r};
  assign elem_lim = (ec_ext > MAX_L) ? MAX_C : CW'(ec_ext);
  assign issue_rd = (cmd.scan_go || cmd.compact_go) && (cnt_r < total_r);
  assign pass_val = pass_r ? fb_r : fa_r;
  assign keep_wr  = cmd.compact_go && v1_r && (al_rdata_r != pass_val);
  assign al_raddr = cmd.seed_read ? AW'(sp_r) : cnt_r[AW-1:0];
  assign dm1      = depth_r - CW'(1);
  assign dm2      = depth_r - CW'(2);
  assign stk_raddr = cmd.stk_rd_below ? dm2[AW-1:0] : dm1[AW-1:0];
  assign wslot    = slot_of(fa_r, fb_r);
  assign sslot    = slot_of(top_r, al_rdata_r);
  assign d_cur    = oob_s3_r ? '1 : dist_rdata_r;
  assign better   = v3_r && !skip_s3_r && (!have_r || (d_cur < best_r));

  always_comb begin
    al_we    = 1'b0;
    al_waddr = cnt_r[AW-1:0];
    al_wdata = 7'(cnt_r);
    if (cmd.init_fill) begin
      al_we = 1'b1;
    end else if (keep_wr) begin
      al_we    = 1'b1;
      al_waddr = wcnt_r[AW-1:0];
      al_wdata = al_rdata_r;
    end else if (cmd.append) begin
      al_we    = 1'b1;
      al_waddr = total_r[AW-1:0];
      al_wdata = ec_r + {1'b0, ms_r};
    end
  end

  always_comb begin
    stk_we    = cmd.seed_push || cmd.push;
    stk_waddr = cmd.push ? depth_r[AW-1:0] : '0;
    stk_wdata = cmd.push ? best_j_r : al_rdata_r;
  end

  always_ff @(posedge clk) begin
    if (al_we) al_mem[al_waddr] <= al_wdata;
    al_rdata_r <= al_mem[al_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata_r <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_write && !slot_oob_r) dist_mem[slot_r] <= dv_r;
    dist_rdata_r <= dist_mem[slot_s2_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r        <= ELEM_COUNT_RST;
      total_r     <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) ec_r <= cfg_wr_data;
      if (cmd.init_set) begin
        total_r <= elem_lim;
        depth_r <= '0;
      end
      if (cmd.compact_end) total_r <= wcnt_r;
      if (cmd.append)      total_r <= total_r + CW'(1);
      if (cmd.seed_push)   depth_r <= CW'(1);
      if (cmd.push)        depth_r <= depth_r + CW'(1);
      if (cmd.trim)        depth_r <= (depth_r >= CW'(2)) ? dm2 : '0;
      v1_r <= issue_rd;
      v2_r <= cmd.scan_go && v1_r;
      v3_r <= v2_r;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_operation;
      fa_r     <= in_first_index;
      fb_r     <= in_second_index;
      dv_r     <= DIST_WIDTH'(in_distance_value);
      ms_r     <= in_merge_step;
      sp_r     <= in_start_position;
      status_r <= ST_OK;
      step_r   <= '0;
    end
    if (cmd.init_set || cmd.scan_begin || cmd.compact_begin || cmd.compact_end) begin
      cnt_r <= '0;
    end else if (cmd.init_fill || issue_rd) begin
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.compact_begin || cmd.compact_end) wcnt_r <= '0;
    else if (keep_wr) wcnt_r <= wcnt_r + CW'(1);
    if (cmd.compact_begin) pass_r <= 1'b0;
    if (cmd.compact_end)   pass_r <= 1'b1;
    if (cmd.slot_calc) begin
      slot_r     <= wslot[SW-1:0];
      slot_oob_r <= wslot[14];
    end
    if (cmd.seed_push) top_r <= al_rdata_r;
    if (cmd.push) begin
      below_r <= top_r;
      top_r   <= best_j_r;
      step_r  <= step_r + CW'(1);
    end
    if (cmd.load_top)   top_r   <= stk_rdata_r;
    if (cmd.load_below) below_r <= stk_rdata_r;
    if (cmd.set_status) status_r <= cmd.status_code;
    // stage b: list entry in hand, form the store slot
    slot_s2_r <= sslot[SW-1:0];
    oob_s2_r  <= sslot[14];
    skip_s2_r <= (al_rdata_r == top_r);
    j_s2_r    <= al_rdata_r;
    // stage c: distance read under way
    oob_s3_r  <= oob_s2_r;
    skip_s3_r <= skip_s2_r;
    j_s3_r    <= j_s2_r;
    // stage d: running strict minimum, first in list order wins ties
    if (cmd.scan_begin) begin
      have_r <= 1'b0;
    end else if (better) begin
      have_r   <= 1'b1;
      best_r   <= d_cur;
      best_j_r <= j_s3_r;
    end
    if (cmd.out_load) begin
      out_status_r       <= status_r;
      out_pair_first_r   <= (depth_r >= CW'(2)) ? below_r : 7'd0;
      out_pair_second_r  <= (depth_r >= CW'(1)) ? top_r : 7'd0;
      out_chain_length_r <= 7'(depth_r);
      out_active_count_r <= 7'(total_r);
    end
  end

  always_comb begin
    stat.op           = op_r;
    stat.depth_zero   = (depth_r == '0);
    stat.start_bad    = ({4'd0, sp_r} >= 10'(total_r));
    stat.step_more    = ({1'b0, step_r} + (CW+1)'(1)) < {1'b0, total_r};
    stat.scan_done    = (cnt_r >= total_r) && !v1_r && !v2_r && !v3_r;
    stat.have         = have_r;
    stat.nb_is_below  = (depth_r > CW'(1)) && (below_r == best_j_r);
    stat.depth_full   = (depth_r >= MAX_C);
    stat.init_done    = (cnt_r >= elem_lim);
    stat.compact_done = (cnt_r >= total_r) && !v1_r;
    stat.pass_last    = pass_r;
    stat.list_full    = (total_r >= MAX_C);
    stat.out_free     = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_pair_first   = out_pair_first_r;
  assign out_pair_second  = out_pair_second_r;
  assign out_chain_length = out_chain_length_r;
  assign out_active_count = out_active_count_r;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= MAX_C)
    else $error("chain depth beyond capacity");
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= MAX_C)
    else $error("active list beyond capacity");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while held");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not shown");
`endif

endmodule

### design/nearest_neighbor_chain_engine_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_chain_engine_unit
// nearest-neighbour-chain engine for agglomerative clustering
// ----------------------------------------------------------------------------
// One item in, one result out. The block holds a symmetric distance store, an
// ordered active list and a chain stack, each in its own memory with one read
// port and one write port, and takes one item at a time. Init loads the list
// with n entries (n = element count, capped at MAX_ELEMENTS); grow runs one
// nearest search for each chain step. Grow time is set by the nearest search,
// which walks the active list through its one read port, one entry per cycle,
// down a four-stage pipe (list read, slot form, distance read, compare).
// Distances are unsigned fixed point; a distance that was never written must
// not be read. A new item is taken while the last result still waits on a
// stalled output.
// ----------------------------------------------------------------------------
module nearest_neighbor_chain_engine_unit
  import nnc_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64,
  parameter int DIST_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_first_index,
  input  logic [6:0]  in_second_index,
  input  logic [31:0] in_distance_value,
  input  logic [5:0]  in_merge_step,
  input  logic [5:0]  in_start_position,
  // element count register
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_pair_first,
  output logic [6:0]  out_pair_second,
  output logic [6:0]  out_chain_length,
  output logic [6:0]  out_active_count
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  nnc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and arithmetic
  nnc_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .DIST_WIDTH   (DIST_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_first_index    (in_first_index),
    .in_second_index   (in_second_index),
    .in_distance_value (in_distance_value),
    .in_merge_step     (in_merge_step),
    .in_start_position (in_start_position),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_pair_first    (out_pair_first),
    .out_pair_second   (out_pair_second),
    .out_chain_length  (out_chain_length),
    .out_active_count  (out_active_count)
  );

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the nearest-neighbour-chain engine
// ----------------------------------------------------------------------------
// All pairs among the first ten cluster indices are loaded first, and every
// list that is searched stays inside that set, so no search ever touches an
// empty store entry. A directed part then hits the corner cases: a bad start,
// no neighbour, a full list on merge, a capped init, index wrap on merge,
// out-of-range writes, trims and unused codes. Random phases at several small
// element counts follow. Most of that traffic is grow, merge-top-pair, trim
// cycles; the rest is noise. A scoreboard predicts each result in order.
// ----------------------------------------------------------------------------
module tb;
  import nnc_pkg::*;

  localparam int MAXE  = 64;
  localparam int SPAN  = 2 * MAXE - 1;
  localparam int DEPTH = SPAN * (SPAN + 1) / 2;
  localparam int KW    = 10;

  typedef struct packed {
    status_t    status;
    logic [6:0] pair_first;
    logic [6:0] pair_second;
    logic [6:0] chain_length;
    logic [6:0] active_count;
  } result_t;

  // predicts the engine and matches its results in order
  class cluster_scoreboard;
    logic [31:0] dstore [DEPTH];
    logic [6:0]  alist [MAXE];
    logic [6:0]  chain [MAXE];
    int          total;
    int          depth;
    int          ecount;
    result_t     awaited_q [$];
    int          errors;
    int          matched;
    int          op_seen [8];
    int          status_seen [4];

    function new();
      ecount = 64;
      total  = 0;
      depth  = 0;
      errors = 0;
      matched = 0;
    endfunction

    task report(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    function automatic bit slot_of(input int a, input int b, output int s);
      int hi;
      int lo;
      hi = a > b ? a : b;
      lo = a > b ? b : a;
      s = hi * (hi + 1) / 2 + lo;
      return hi < SPAN;
    endfunction

    function automatic logic [31:0] read_dist(input int a, input int b);
      int s;
      if (!slot_of(a, b, s)) return '1;
      return dstore[s];
    endfunction

    // nearest active cluster, strict minimum so the first in list order wins
    function automatic bit nearest(input int top, output int found);
      bit          have;
      logic [31:0] best;
      logic [31:0] d;
      have = 0;
      best = 0;
      found = 0;
      for (int i = 0; i < total; i++) begin
        if (alist[i] == top) continue;
        d = read_dist(top, alist[i]);
        if (!have || d < best) begin
          have = 1;
          best = d;
          found = alist[i];
        end
      end
      return have;
    endfunction

    function automatic status_t grow(input int start);
      int nb;
      if (depth == 0) begin
        if (start >= total) return ST_BAD;
        chain[0] = alist[start];
        depth = 1;
      end
      for (int step = 0; step + 1 < total; step++) begin
        if (!nearest(chain[depth - 1], nb)) return ST_NONE;
        if (depth > 1 && chain[depth - 2] == nb) break;
        if (depth >= MAXE) return ST_FULL;
        chain[depth] = 7'(nb);
        depth++;
      end
      return ST_OK;
    endfunction

    function automatic void drop_all(input logic [6:0] v);
      int w;
      w = 0;
      for (int r = 0; r < total; r++)
        if (alist[r] != v) alist[w++] = alist[r];
      total = w;
    endfunction

    function automatic void note(input logic [2:0] op, input logic [6:0] fi,
                                 input logic [6:0] se, input logic [31:0] dv,
                                 input logic [5:0] ms, input logic [5:0] sp);
      result_t r;
      int      s;
      r = '0;
      r.status = ST_OK;
      op_seen[op]++;
      case (op)
        OP_INIT: begin
          total = ecount > MAXE ? MAXE : ecount;
          for (int i = 0; i < total; i++) alist[i] = 7'(i);
          depth = 0;
        end
        OP_WRITE: if (slot_of(fi, se, s)) dstore[s] = dv;
        OP_GROW: r.status = grow(sp);
        OP_MERGE: begin
          drop_all(fi);
          drop_all(se);
          if (total >= MAXE) r.status = ST_FULL;
          else begin
            alist[total] = 7'(ecount + ms);
            total++;
          end
        end
        OP_TRIM: depth = depth >= 2 ? depth - 2 : 0;
        default: ;
      endcase
      r.pair_first   = depth >= 2 ? chain[depth - 2] : 7'd0;
      r.pair_second  = depth >= 1 ? chain[depth - 1] : 7'd0;
      r.chain_length = 7'(depth);
      r.active_count = 7'(total);
      awaited_q.push_back(r);
    endfunction

    task check(input result_t got);
      result_t want;
      if (awaited_q.size() == 0) begin
        report("result with nothing awaited");
      end else begin
        want = awaited_q.pop_front();
        matched++;
        status_seen[want.status]++;
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.pair_first !== want.pair_first)
          report($sformatf("pair_first %0d, want %0d", got.pair_first, want.pair_first));
        if (got.pair_second !== want.pair_second)
          report($sformatf("pair_second %0d, want %0d", got.pair_second,
                           want.pair_second));
        if (got.chain_length !== want.chain_length)
          report($sformatf("chain_length %0d, want %0d", got.chain_length,
                           want.chain_length));
        if (got.active_count !== want.active_count)
          report($sformatf("active_count %0d, want %0d", got.active_count,
                           want.active_count));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_operation;
  logic [6:0]  in_first_index;
  logic [6:0]  in_second_index;
  logic [31:0] in_distance_value;
  logic [5:0]  in_merge_step;
  logic [5:0]  in_start_position;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [6:0]  out_pair_first;
  logic [6:0]  out_pair_second;
  logic [6:0]  out_chain_length;
  logic [6:0]  out_active_count;

  cluster_scoreboard sb;
  int burst_left;
  int stall_mode;
  bit hold_req;
  int merge_iter;

  nearest_neighbor_chain_engine_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_first_index   (in_first_index),
    .in_second_index  (in_second_index),
    .in_distance_value(in_distance_value),
    .in_merge_step    (in_merge_step),
    .in_start_position(in_start_position),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_pair_first   (out_pair_first),
    .out_pair_second  (out_pair_second),
    .out_chain_length (out_chain_length),
    .out_active_count (out_active_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling, far beyond what the whole run needs
  initial begin
    #50_000_000;
    $display("FAIL nearest_neighbor_chain_engine_unit");
    $finish;
  end

  // result side: random stall patterns, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= $urandom_range(0, 1);
          default: out_stall <= (tick % 7 < 3);
        endcase
      end
    end
  end

  // check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check({status_t'(out_status), out_pair_first, out_pair_second,
                out_chain_length, out_active_count});
  end

  // offer one item and hold it until taken, then maybe pause
  task automatic send_item(input logic [2:0] op, input logic [6:0] fi,
                           input logic [6:0] se, input logic [31:0] dv,
                           input logic [5:0] ms, input logic [5:0] sp);
    int gap;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_first_index    <= fi;
    in_second_index   <= se;
    in_distance_value <= dv;
    in_merge_step     <= ms;
    in_start_position <= sp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(op, fi, se, dv, ms, sp);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // distance with frequent ties, now and then anywhere in the full range
  function automatic logic [31:0] rand_dist();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'(2000 + $urandom_range(0, 3));
  endfunction

  // drop valid and wait until every result is back before going on
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(input logic [6:0] n);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.ecount = n;
  endtask

  task automatic send_init();
    send_item(OP_INIT, 7'($urandom), 7'($urandom), $urandom, 6'($urandom), 6'($urandom));
    merge_iter = 0;
  endtask

  // noise that keeps every searched index inside the loaded set
  task automatic send_noise();
    int hi_s;
    case ($urandom_range(0, 4))
      0: begin
        hi_s = $urandom_range(1, KW - 1);
        send_item(OP_WRITE, 7'(hi_s), 7'($urandom_range(0, hi_s - 1)), rand_dist(),
                  6'($urandom), 6'($urandom));
      end
      1: send_item(OP_WRITE, 7'(SPAN + $urandom_range(0, 127 - SPAN)), 7'($urandom),
                   $urandom, 6'($urandom), 6'($urandom));
      2: send_item(3'($urandom_range(OP_TRIM + 1, 7)), 7'($urandom), 7'($urandom),
                   $urandom, 6'($urandom), 6'($urandom));
      3: send_item(OP_GROW, 7'($urandom), 7'($urandom), $urandom, 6'($urandom),
                   6'($urandom));
      default: send_item(OP_TRIM, 7'($urandom), 7'($urandom), $urandom, 6'($urandom),
                         6'($urandom));
    endcase
  endtask

  // one turn of the clustering loop: grow, merge the top pair, trim it off, or now and then a fresh init
  task automatic cluster_turn();
    if (sb.total < 2 || sb.ecount + merge_iter >= KW || $urandom_range(0, 9) == 0) begin
      send_init();
    end else begin
      send_item(OP_GROW, 7'($urandom), 7'($urandom), $urandom, 6'($urandom),
                6'($urandom_range(0, sb.total - 1)));
      if (sb.depth >= 2) begin
        send_item(OP_MERGE, sb.chain[sb.depth - 1], sb.chain[sb.depth - 2], $urandom,
                  6'(merge_iter), 6'($urandom));
        merge_iter++;
        send_item(OP_TRIM, 7'($urandom), 7'($urandom), $urandom, 6'($urandom),
                  6'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [6:0] phase_count [4];
    int         sent;
    sb = new();
    burst_left = 0;
    stall_mode = 0;
    hold_req = 1'b0;
    merge_iter = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_INIT;
    in_first_index = '0;
    in_second_index = '0;
    in_distance_value = '0;
    in_merge_step = '0;
    in_start_position = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = ELEM_COUNT_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every pair among the low indices, in a narrow band so ties are common
    for (int hi = 1; hi < KW; hi++)
      for (int lo = 0; lo < hi; lo++)
        send_item(OP_WRITE, 7'(hi), 7'(lo), rand_dist(), 6'($urandom), 6'($urandom));

    // directed corners
    send_item(OP_GROW, 0, 0, 0, 0, 0);                 // empty list: bad start
    send_item(OP_TRIM, 0, 0, 0, 0, 0);                 // trim on empty chain
    send_item(3'd5, 7'h7f, 7'h7f, '1, '1, '1);         // unused codes
    send_item(3'd6, 7'h15, 7'h2a, 32'h1234, 6'd9, 6'd3);
    send_item(3'd7, 0, 0, 0, 0, 0);
    send_item(OP_WRITE, 7'h7f, 3, 5, 0, 0);            // beyond the store: dropped
    send_item(OP_WRITE, 3, 7'h7f, 5, 0, 0);
    send_item(OP_INIT, 0, 0, 0, 0, 0);                 // list of 64
    send_item(OP_MERGE, 120, 120, 0, 0, 0);            // list still full
    set_count(127);
    send_item(OP_INIT, 0, 0, 0, 0, 0);                 // capped at 64
    send_item(OP_MERGE, 0, 1, 0, 0, 0);                // new index 127
    send_item(OP_MERGE, 7'h7f, 7'h7f, 0, 1, 0);        // new index wraps to 0
    set_count(2);
    send_item(OP_INIT, 0, 0, 0, 0, 0);
    send_item(OP_GROW, 0, 0, 0, 0, 0);                 // pair 0 and 1
    send_item(OP_MERGE, 0, 1, 0, 0, 0);
    send_item(OP_MERGE, 9, 9, 0, 0, 0);                // duplicates of the new cluster
    send_item(OP_MERGE, 9, 9, 0, 0, 0);
    send_item(OP_TRIM, 0, 0, 0, 0, 0);
    send_item(OP_GROW, 0, 0, 0, 0, 0);                 // top has no other neighbour
    send_item(OP_TRIM, 0, 0, 0, 0, 0);
    send_item(OP_GROW, 0, 0, 0, 0, 6'd5);              // start beyond the list

    // back-pressure: receiver holds off while writes keep coming
    drain();
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++)
      send_item(OP_WRITE, 7'(k), 7'(k + 1), 32'd2001, 0, 0);

    phase_count[0] = 7'd5;
    phase_count[1] = 7'd6;
    phase_count[2] = 7'($urandom_range(3, 8));
    phase_count[3] = 7'd9;
    for (int p = 0; p < 4; p++) begin
      set_count(phase_count[p]);
      send_init();
      sent = 1;
      while (sent < 17) begin
        if ($urandom_range(0, 3) == 0) begin
          send_noise();
          sent++;
        end else begin
          cluster_turn();
          sent += 3;
        end
      end
    end
    drain();

    $display("ops seen: init %0d write %0d grow %0d merge %0d trim %0d unused %0d",
             sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3], sb.op_seen[4],
             sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7]);
    $display("%0d results checked; status ok %0d none %0d bad %0d full %0d",
             sb.matched, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3]);
    if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
      $display("PASS nearest_neighbor_chain_engine_unit");
    end else begin
      $display("FAIL nearest_neighbor_chain_engine_unit");
    end
    $finish;
  end

endmodule

### nearest_neighbor_chain_engine_unit.f
design/nnc_pkg.sv
design/nnc_ctrl.sv
design/nnc_dpath.sv
design/nearest_neighbor_chain_engine_unit.sv
test/tb.sv
